[src/sed_pkg.sv]
`default_nettype none

package sed_pkg;

    // Signed working width for screen positions and window checks
    localparam int POS_W = 13;

    // Screen window, offset by 32 on both axes
    localparam logic signed [POS_W-1:0] WIN_MIN   = 13'sd32;
    localparam logic signed [POS_W-1:0] WIN_X_MAX = 13'sd352;
    localparam logic signed [POS_W-1:0] WIN_Y_MAX = 13'sd256;
    localparam logic signed [POS_W-1:0] ROW_TOP   = 13'sd24;
    localparam logic signed [POS_W-1:0] TILE_PIX  = 13'sd8;

    // A row is the final visible one when the next row falls off the window
    localparam logic signed [POS_W-1:0] ROW_LAST_UP = ROW_TOP + TILE_PIX;
    localparam logic signed [POS_W-1:0] ROW_LAST_DN = WIN_Y_MAX - TILE_PIX;

    // Tile codes per page row (256 pixels / 8)
    localparam logic [17:0] CODES_PER_ROW = 18'd32;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ROWS
    } sed_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic decode;
        logic step;
    } sed_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic visible;
        logic emit;
        logic row_end;
    } sed_status_t;

endpackage

`default_nettype wire

[src/sprite_entry_row_decoder_unit.sv]
`default_nettype none

// Sprite entry row decoder.
// Request channel: drive the six entry words and raise start; the request is
// taken at the rising edge where start is high and busy is low. Inputs need
// only be valid at that edge.
// Result channel: each row command is shown for one cycle with result_valid
// high; last_row marks the final command of the entry. The receiver cannot
// stall, so commands are never held or repeated.
// Sequence: after acceptance the block decodes the entry and tests the window,
// then walks the 8x8 tile rows (up to 33), one row command per cycle,
// skipped rows still taking their step. An entry that is disabled or off
// the window is dropped after the decode step and gives nothing.
// A full entry occupies the block for the whole row walk. Busy is low in idle
// before the next request is taken, so a new entry is only taken once the
// last one is through.
// Reset puts the controller in idle with busy low; the datapath registers
// are not reset.
module sprite_entry_row_decoder_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [15:0]        attr_word,
    input  wire logic [15:0]        source_word,
    input  wire logic [15:0]        color_word,
    input  wire logic [15:0]        size_word,
    input  wire logic [15:0]        ypos_word,
    input  wire logic [15:0]        xpos_word,
    output logic                    result_valid,
    output logic [17:0]             tile_code,
    output logic [8:0]              screen_y,
    output logic signed [10:0]      first_x,
    output logic                    x_backward,
    output logic [5:0]              tile_count,
    output logic [3:0]              palette,
    output logic [1:0]              flip_mode,
    output logic                    last_row
);

    sed_pkg::sed_cmd_t    cmd;
    sed_pkg::sed_status_t status;

    sed_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .status       (status),
        .cmd          (cmd),
        .busy         (busy),
        .result_valid (result_valid)
    );

    sed_datapath u_datapath (
        .clk         (clk),
        .cmd         (cmd),
        .attr_word   (attr_word),
        .source_word (source_word),
        .color_word  (color_word),
        .size_word   (size_word),
        .ypos_word   (ypos_word),
        .xpos_word   (xpos_word),
        .status      (status),
        .tile_code   (tile_code),
        .screen_y    (screen_y),
        .first_x     (first_x),
        .x_backward  (x_backward),
        .tile_count  (tile_count),
        .palette     (palette),
        .flip_mode   (flip_mode),
        .last_row    (last_row)
    );

    // A row command only comes out while an entry is in work
    a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("row command outside an entry");

    // The final row closes the entry
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last_row) |=> (!result_valid && !busy))
        else $error("row command after last row");

    // An accepted request always occupies the block for the decode cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !result_valid))
        else $error("decode cycle missing after accept");

    // Tile count stays within one to thirty-three
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((tile_count != 6'd0) && (tile_count <= 6'd33)))
        else $error("tile count out of range");

endmodule

`default_nettype wire

[src/sed_ctrl.sv]
`default_nettype none

module sed_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire sed_pkg::sed_status_t status,
    output sed_pkg::sed_cmd_t        cmd,
    output logic                     busy,
    output logic                     result_valid
);

    sed_pkg::sed_state_t state_reg;
    sed_pkg::sed_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sed_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        busy         = 1'b1;
        result_valid = 1'b0;
        unique case (state_reg)
            sed_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = sed_pkg::ST_DECODE;
                end
            end
            sed_pkg::ST_DECODE:
            begin
                // entry skipped when disabled or off the window
                cmd.decode = 1'b1;
                state_next = status.visible ? sed_pkg::ST_ROWS : sed_pkg::ST_IDLE;
            end
            sed_pkg::ST_ROWS:
            begin
                cmd.step     = 1'b1;
                result_valid = status.emit;
                if (status.row_end)
                begin
                    state_next = sed_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sed_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[src/sed_datapath.sv]
`default_nettype none

module sed_datapath (
    input  wire logic                clk,
    input  wire sed_pkg::sed_cmd_t   cmd,
    input  wire logic [15:0]         attr_word,
    input  wire logic [15:0]         source_word,
    input  wire logic [15:0]         color_word,
    input  wire logic [15:0]         size_word,
    input  wire logic [15:0]         ypos_word,
    input  wire logic [15:0]         xpos_word,
    output sed_pkg::sed_status_t     status,
    output logic [17:0]              tile_code,
    output logic [8:0]               screen_y,
    output logic signed [10:0]       first_x,
    output logic                     x_backward,
    output logic [5:0]               tile_count,
    output logic [3:0]               palette,
    output logic [1:0]               flip_mode,
    output logic                     last_row
);

    localparam int PW = sed_pkg::POS_W;

    // Captured entry fields
    logic        enable_reg;
    logic        fx_reg;
    logic        fy_reg;
    logic [7:0]  tx_reg;
    logic [7:0]  ty_reg;
    logic [6:0]  page_reg;
    logic [3:0]  pal_reg;
    logic [7:0]  wm1_reg;
    logic [7:0]  hm1_reg;
    logic [9:0]  ypos_reg;
    logic [10:0] xpos_reg;

    // Row walk state
    logic [17:0]          code_reg;
    logic signed [PW-1:0] dy_reg;
    logic [10:0]          first_x_reg;
    logic [5:0]           xnum_reg;
    logic [5:0]           ynum_reg;
    logic [5:0]           k_reg;

    // Decode terms
    logic [8:0]           xsize;
    logic [8:0]           ysize;
    logic [9:0]           xend;
    logic [9:0]           yend;
    logic [6:0]           xnum_full;
    logic [6:0]           ynum_full;
    logic signed [PW-1:0] sx;
    logic signed [PW-1:0] sy;
    logic signed [PW-1:0] xsize_s;
    logic signed [PW-1:0] ysize_s;
    logic signed [PW-1:0] txf_s;
    logic signed [PW-1:0] tyf_s;
    logic signed [PW-1:0] first_x_d;
    logic signed [PW-1:0] dy0_d;
    logic                 visible;
    logic                 emit;
    logic                 row_end;

    // Entry capture on request accept
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            enable_reg <= attr_word[2];
            fx_reg     <= attr_word[0];
            fy_reg     <= attr_word[1];
            tx_reg     <= source_word[7:0];
            ty_reg     <= source_word[15:8];
            page_reg   <= color_word[6:0];
            pal_reg    <= color_word[15:12];
            wm1_reg    <= size_word[7:0];
            hm1_reg    <= size_word[15:8];
            ypos_reg   <= ypos_word[9:0];
            xpos_reg   <= xpos_word[10:0];
        end
    end

    // Size, tile spans and signed position
    always_comb
    begin
        xsize     = {1'b0, wm1_reg} + 9'd1;
        ysize     = {1'b0, hm1_reg} + 9'd1;
        xend      = {2'b0, tx_reg} + {1'b0, xsize} + 10'd7;
        yend      = {2'b0, ty_reg} + {1'b0, ysize} + 10'd7;
        xnum_full = xend[9:3] - {2'b0, tx_reg[7:3]};
        ynum_full = yend[9:3] - {2'b0, ty_reg[7:3]};
        sx        = $signed({{(PW-11){xpos_reg[10]}}, xpos_reg}) + sed_pkg::WIN_MIN;
        sy        = $signed({{(PW-10){ypos_reg[9]}}, ypos_reg}) + sed_pkg::WIN_MIN;
        xsize_s   = $signed({{(PW-9){1'b0}}, xsize});
        ysize_s   = $signed({{(PW-9){1'b0}}, ysize});
        txf_s     = $signed({{(PW-3){1'b0}}, tx_reg[2:0]});
        tyf_s     = $signed({{(PW-3){1'b0}}, ty_reg[2:0]});
    end

    // Window test on the unaligned rectangle
    always_comb
    begin
        visible = enable_reg
               && !(sx > sed_pkg::WIN_X_MAX)
               && !(sx + xsize_s - 13'sd1 < sed_pkg::WIN_MIN)
               && !(sy > sed_pkg::WIN_Y_MAX)
               && !(sy + ysize_s - 13'sd1 < sed_pkg::WIN_MIN);
    end

    // First code tile x and first row y after sub-tile alignment
    always_comb
    begin
        if (fx_reg)
        begin
            first_x_d = sx + xsize_s + txf_s - sed_pkg::TILE_PIX;
        end
        else
        begin
            first_x_d = sx - txf_s;
        end
        if (fy_reg)
        begin
            dy0_d = sy + ysize_s + tyf_s - sed_pkg::TILE_PIX;
        end
        else
        begin
            dy0_d = sy - tyf_s;
        end
    end

    // Row walk: one tile row per step
    always_ff @(posedge clk)
    begin
        if (cmd.decode)
        begin
            code_reg    <= {1'b0, page_reg, ty_reg[7:3], tx_reg[7:3]};
            dy_reg      <= dy0_d;
            first_x_reg <= first_x_d[10:0];
            xnum_reg    <= xnum_full[5:0];
            ynum_reg    <= ynum_full[5:0];
            k_reg       <= '0;
        end
        else if (cmd.step)
        begin
            code_reg <= code_reg + sed_pkg::CODES_PER_ROW;
            dy_reg   <= fy_reg ? dy_reg - sed_pkg::TILE_PIX : dy_reg + sed_pkg::TILE_PIX;
            k_reg    <= k_reg + 6'd1;
        end
    end

    // Row visibility and end of sprite
    always_comb
    begin
        emit    = (dy_reg >= sed_pkg::ROW_TOP) && (dy_reg <= sed_pkg::WIN_Y_MAX);
        row_end = (k_reg == ynum_reg - 6'd1)
               || (dy_reg > sed_pkg::WIN_Y_MAX)
               || (emit && (fy_reg ? (dy_reg < sed_pkg::ROW_LAST_UP)
                                   : (dy_reg > sed_pkg::ROW_LAST_DN)));
    end

    // Status to the controller
    assign status = {visible, emit, row_end};

    // Row command fields
    assign tile_code  = code_reg;
    assign screen_y   = dy_reg[8:0];
    assign first_x    = $signed(first_x_reg);
    assign x_backward = fx_reg;
    assign tile_count = xnum_reg;
    assign palette    = pal_reg;
    assign flip_mode  = {fy_reg, fx_reg};
    assign last_row   = emit && row_end;

endmodule

`default_nettype wire

[tb/tb.sv]
`default_nettype none

module tb;

    // Window and row geometry, offset by 32 on both axes
    localparam int WIN_LO      = 32;
    localparam int WIN_X_HI    = 352;
    localparam int WIN_Y_HI    = 256;
    localparam int ROW_TOP_Y   = 24;
    localparam int TILES_ACROSS = 32;
    localparam int IDLE_PCT    = 37;
    localparam int RANDOM_ENTRIES = 288;
    localparam int DRAIN_CYCLES = 40;

    // One sprite list entry as it goes into the block
    typedef struct packed {
        logic [15:0] attr;
        logic [15:0] src;
        logic [15:0] color;
        logic [15:0] size;
        logic [15:0] ypos;
        logic [15:0] xpos;
    } sprite_entry_t;

    // One row command as it comes out of the block
    typedef struct packed {
        logic [17:0]        code;
        logic [8:0]         y;
        logic signed [10:0] x;
        logic               back;
        logic [5:0]         count;
        logic [3:0]         pal;
        logic [1:0]         flip;
        logic               last;
    } row_cmd_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [15:0] attr_word = '0;
    logic [15:0] source_word = '0;
    logic [15:0] color_word = '0;
    logic [15:0] size_word = '0;
    logic [15:0] ypos_word = '0;
    logic [15:0] xpos_word = '0;

    logic               busy;
    logic               result_valid;
    logic [17:0]        tile_code;
    logic [8:0]         screen_y;
    logic signed [10:0] first_x;
    logic               x_backward;
    logic [5:0]         tile_count;
    logic [3:0]         palette;
    logic [1:0]         flip_mode;
    logic               last_row;

    sprite_entry_t entries_to_send[$];
    row_cmd_t      rows_due[$];
    int            entries_total = 0;
    int            entries_taken = 0;
    int            entries_issued = 0;
    int            errors = 0;

    sprite_entry_row_decoder_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .attr_word    (attr_word),
        .source_word  (source_word),
        .color_word   (color_word),
        .size_word    (size_word),
        .ypos_word    (ypos_word),
        .xpos_word    (xpos_word),
        .result_valid (result_valid),
        .tile_code    (tile_code),
        .screen_y     (screen_y),
        .first_x      (first_x),
        .x_backward   (x_backward),
        .tile_count   (tile_count),
        .palette      (palette),
        .flip_mode    (flip_mode),
        .last_row     (last_row)
    );

    // Clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Break one entry into the row commands it should produce
    function automatic void decode_rows(input sprite_entry_t e);
        int tx, ty, xsize, ysize, xnum, ynum, sx, sy, x_first, row, dy, k, base;
        bit fx, fy;
        row_cmd_t cmd;
        row_cmd_t found[$];
        if (e.attr[2] == 1'b0)
            return;
        fx = e.attr[0];
        fy = e.attr[1];
        tx = int'(e.src[7:0]);
        ty = int'(e.src[15:8]);
        base = tx / 8 + (ty / 8) * TILES_ACROSS
             + int'(e.color[6:0]) * TILES_ACROSS * TILES_ACROSS;
        xsize = int'(e.size[7:0]) + 1;
        ysize = int'(e.size[15:8]) + 1;
        xnum = (tx + xsize + 7) / 8 - tx / 8;
        ynum = (ty + ysize + 7) / 8 - ty / 8;
        sx = int'(e.xpos[9:0]) - (e.xpos[10] ? 1024 : 0) + WIN_LO;
        sy = int'(e.ypos[8:0]) - (e.ypos[9] ? 512 : 0) + WIN_LO;

        // whole entry off the window
        if (sx > WIN_X_HI || sx + xsize - 1 < WIN_LO ||
            sy > WIN_Y_HI || sy + ysize - 1 < WIN_LO)
            return;

        // align to the tile grid; with flip x the first code sits rightmost
        if (fx)
        begin
            sx = sx - (xnum * 8 - xsize - tx % 8);
            x_first = sx + (xnum - 1) * 8;
        end
        else
        begin
            sx = sx - tx % 8;
            x_first = sx;
        end
        if (fy)
            sy = sy - (ynum * 8 - ysize - ty % 8);
        else
            sy = sy - ty % 8;

        // walk rows in code order; first row past the bottom ends the entry
        for (k = 0; k < ynum; k++)
        begin
            row = fy ? (ynum - 1 - k) : k;
            dy = sy + row * 8;
            if (dy > WIN_Y_HI)
                break;
            if (dy < ROW_TOP_Y)
                continue;
            cmd.code  = 18'(base + k * TILES_ACROSS);
            cmd.y     = 9'(dy);
            cmd.x     = 11'(x_first);
            cmd.back  = fx;
            cmd.count = 6'(xnum);
            cmd.pal   = e.color[15:12];
            cmd.flip  = {fy, fx};
            cmd.last  = 1'b0;
            found.push_back(cmd);
        end
        if (found.size() != 0)
            found[found.size() - 1].last = 1'b1;
        foreach (found[i])
            rows_due.push_back(found[i]);
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic add_entry(input logic [15:0] a, input logic [15:0] s,
                             input logic [15:0] c, input logic [15:0] z,
                             input logic [15:0] y, input logic [15:0] x);
        entries_to_send.push_back({a, s, c, z, y, x});
    endtask

    // Signed position in the low bits, random junk above
    function automatic logic [15:0] pos_word(input int v, input int nbits);
        logic [15:0] mask;
        mask = 16'((1 << nbits) - 1);
        return (16'($urandom) & ~mask) | (16'(v) & mask);
    endfunction

    // Request driver: new request whenever the slot is free, idling at random
    always @(posedge clk)
    begin : drive
        sprite_entry_t nxt;
        if (!rst_n)
            start <= 1'b0;
        else if (!start || !busy)
        begin
            if (entries_to_send.size() != 0 &&
                ((entries_issued >= 150 && entries_issued < 230) ||
                 $urandom_range(0, 99) >= IDLE_PCT))
            begin
                nxt = entries_to_send.pop_front();
                attr_word   <= nxt.attr;
                source_word <= nxt.src;
                color_word  <= nxt.color;
                size_word   <= nxt.size;
                ypos_word   <= nxt.ypos;
                xpos_word   <= nxt.xpos;
                start       <= 1'b1;
                entries_issued++;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: predict on accepted requests, check every row command
    always @(posedge clk)
    begin : watch
        row_cmd_t want;
        if (rst_n)
        begin
            if (start === 1'b1 && busy === 1'b0)
            begin
                decode_rows({attr_word, source_word, color_word, size_word,
                             ypos_word, xpos_word});
                entries_taken++;
            end
            if (result_valid === 1'b1)
            begin
                if (rows_due.size() == 0)
                begin
                    $display("%0t: unexpected row command, expected none actual code %0h y %0d",
                             $time, tile_code, screen_y);
                    errors++;
                end
                else
                begin
                    want = rows_due.pop_front();
                    compare_field("tile_code", 32'(want.code), 32'(tile_code));
                    compare_field("screen_y", 32'(want.y), 32'(screen_y));
                    compare_field("first_x", 32'(want.x), 32'(first_x));
                    compare_field("x_backward", 32'(want.back), 32'(x_backward));
                    compare_field("tile_count", 32'(want.count), 32'(tile_count));
                    compare_field("palette", 32'(want.pal), 32'(palette));
                    compare_field("flip_mode", 32'(want.flip), 32'(flip_mode));
                    compare_field("last_row", 32'(want.last), 32'(last_row));
                end
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        int pick;
        logic [15:0] a, z;

        // disabled, with and without the other bits set
        add_entry(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        add_entry(16'hFFFB, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // single tile at the window corner
        add_entry(16'h0004, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        // largest entry, misaligned source: 33x33 tiles, plain and flipped
        add_entry(16'h0004, 16'h0101, 16'hF07F, 16'hFFFF, 16'h0000, 16'h0000);
        add_entry(16'h0007, 16'h0101, 16'h507F, 16'hFFFF, 16'h0000, 16'h0000);
        // at the right and bottom window limits, then just past them
        add_entry(16'h0004, 16'h0305, 16'h1003, 16'h0F0F, 16'd224, 16'd320);
        add_entry(16'h0004, 16'h0000, 16'h0000, 16'h0F0F, 16'd100, 16'd321);
        add_entry(16'h0004, 16'h0000, 16'h0000, 16'h0F0F, 16'd225, 16'd100);
        // right edge and bottom edge just short of the window, then touching
        add_entry(16'h0004, 16'h0000, 16'h0000, 16'h000F, 16'd100, 16'h07F0);
        add_entry(16'h0004, 16'h0000, 16'h0000, 16'h0F00, 16'h03F0, 16'd100);
        add_entry(16'h0004, 16'h0000, 16'h0000, 16'h1010, 16'h03F0, 16'h07F0);
        // rows above the top are skipped, plain and flip y
        add_entry(16'h0004, 16'h0000, 16'h2001, 16'h3F07, 16'h03EC, 16'd50);
        add_entry(16'h0006, 16'h0000, 16'h2001, 16'h3F07, 16'h03EC, 16'd50);
        // row below the bottom ends the entry; with flip y nothing is left
        add_entry(16'h0006, 16'h0000, 16'h0000, 16'h3F07, 16'd200, 16'd50);
        add_entry(16'h0004, 16'h0000, 16'h0000, 16'h3F07, 16'd200, 16'd50);
        // flip x with a sub-tile source offset
        add_entry(16'h0005, 16'h0013, 16'h3002, 16'h0714, 16'd40, 16'd100);
        // x extremes, both off
        add_entry(16'h0004, 16'h0000, 16'h0000, 16'h00FF, 16'd40, 16'h0400);
        add_entry(16'h0004, 16'h0000, 16'h0000, 16'h0000, 16'd40, 16'h03FF);
        // ignored upper bits set on every word that has them
        add_entry(16'hFFFC, 16'h0000, 16'h8F80, 16'h0000, 16'hFC00, 16'hF800);
        // source at the far corner of the page
        add_entry(16'h0004, 16'hFFFF, 16'hFFFF, 16'h0000, 16'd60, 16'd60);
        // flip x with the left edge of the entry at a negative x
        add_entry(16'h0005, 16'h0004, 16'h0001, 16'h07C8, 16'd80, 16'h07C0);
        // short entry straddling a tile row boundary
        add_entry(16'h0004, 16'h0700, 16'h0000, 16'h0100, 16'd120, 16'd150);

        // Random entries: mostly enabled and near the window
        for (int i = 0; i < RANDOM_ENTRIES; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                add_entry(16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom), 16'($urandom), 16'($urandom));
            else
            begin
                a = 16'($urandom) | 16'h0004;
                if (pick < 14)
                    a[2] = 1'b0;
                if (pick < 30)
                    z = 16'($urandom);
                else
                    z = {2'b00, 6'($urandom), 8'($urandom_range(0, 63))};
                add_entry(a, 16'($urandom), 16'($urandom), z,
                          pos_word(int'($urandom_range(0, 300)) - 72, 10),
                          pos_word(int'($urandom_range(0, 640)) - 300, 11));
            end
        end
        entries_total = entries_to_send.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (entries_taken < entries_total)
            @(posedge clk);
        while (rows_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && rows_due.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #800000;
        $display("tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
